// File: rtl/msort_pkg.sv
`timescale 1ns / 1ps
package msort_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic  ins;
        logic  shift;
        data_t ins_value;
    } cell_ctrl_t;

endpackage

// File: rtl/msort_if.sv
`timescale 1ns / 1ps
interface ms_in_if;
    import msort_pkg::*;

    logic  valid;
    logic  ready;
    data_t value;
    logic  batch_end;

    modport source (output valid, output value, output batch_end, input ready);
    modport sink   (input valid, input value, input batch_end, output ready);
endinterface

interface ms_out_if;
    import msort_pkg::*;

    logic  valid;
    logic  ready;
    data_t sorted_value;
    logic  final_item;
    logic  overflowed;

    modport source (output valid, output sorted_value, output final_item,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input final_item,
                    input overflowed, output ready);
endinterface

// File: rtl/msort_cell.sv
`timescale 1ns / 1ps
module msort_cell
    import msort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  data_t      prev_value,
    input  logic       prev_valid,
    input  logic       prev_lt,
    input  data_t      next_value,
    input  logic       next_valid,
    output data_t      value,
    output logic       valid,
    output logic       lt
);

    data_t value_reg;
    data_t value_next;
    logic  valid_reg;
    logic  valid_next;

    // an empty cell counts as +infinity
    assign lt = !valid_reg || (ctrl.ins_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.ins)
        begin
            if (prev_lt)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else if (lt)
            begin
                value_next = ctrl.ins_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/msort_chain.sv
`timescale 1ns / 1ps
module msort_chain
    import msort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    output data_t      head_value,
    output logic       head_valid
);

    data_t value_w [CAPACITY];
    logic  valid_w [CAPACITY];
    logic  lt_w    [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            data_t p_value;
            logic  p_valid;
            logic  p_lt;
            data_t n_value;
            logic  n_valid;

            if (i == 0)
            begin : g_first
                assign p_value = '0;
                assign p_valid = 1'b0;
                assign p_lt    = 1'b0;
            end
            else
            begin : g_mid
                assign p_value = value_w[i-1];
                assign p_valid = valid_w[i-1];
                assign p_lt    = lt_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign n_value = '0;
                assign n_valid = 1'b0;
            end
            else
            begin : g_body
                assign n_value = value_w[i+1];
                assign n_valid = valid_w[i+1];
            end

            msort_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_value (p_value),
                .prev_valid (p_valid),
                .prev_lt    (p_lt),
                .next_value (n_value),
                .next_valid (n_valid),
                .value      (value_w[i]),
                .valid      (valid_w[i]),
                .lt         (lt_w[i])
            );
        end
    endgenerate

    assign head_value = value_w[0];
    assign head_valid = valid_w[0];

endmodule

// File: rtl/merge_sorter.sv
`timescale 1ns / 1ps
// Batch sorter for signed 32-bit values.
// in_ch carries one element per transaction; batch_end = 1 marks the element
// that closes the batch. out_ch returns the batch in ascending order, one
// element per transaction, with final_item on the greatest element and
// overflowed on every element of a batch that exceeded CAPACITY entries.
// Elements past CAPACITY are dropped; a dropped closing element still closes.
// Elements are kept sorted as they arrive in a row of CAPACITY cells: each
// cell compares the incoming element with its own and keeps, takes or passes
// on, so the row takes elements back to back while loading.
// The first result is offered in the cycle after the closing element is
// taken; results then follow one per cycle while out_ch.ready is high, the
// row shifting toward its head on each output transaction. in_ch.ready is
// low while a batch drains.
// Receiver stall: holding out_ch.ready low freezes the row; nothing is lost.
// Reset empties every cell, clears the element count and overflow flag, and
// leaves the block ready for a new batch.
module merge_sorter
    import msort_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ms_in_if.sink   in_ch,
    ms_out_if.source out_ch
);

    state_t     state_reg;
    state_t     state_next;
    count_t     count_reg;
    count_t     count_next;
    logic       drop_reg;
    logic       drop_next;
    cell_ctrl_t ctrl;
    data_t      head_value;
    logic       head_valid;
    logic       in_acc;
    logic       out_acc;
    logic       full;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign full    = (count_reg == count_t'(CAPACITY));

    msort_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .head_value (head_value),
        .head_valid (head_valid)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        ctrl.ins       = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.ins_value = in_ch.value;
        in_ch.ready    = 1'b0;
        out_ch.valid   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ch.ready = 1'b1;
                if (in_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + count_t'(1);
                    end
                    if (in_ch.batch_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                out_ch.valid = 1'b1;
                if (out_acc)
                begin
                    ctrl.shift = 1'b1;
                    count_next = count_reg - count_t'(1);
                    if (count_reg == count_t'(1))
                    begin
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    assign out_ch.sorted_value = head_value;
    assign out_ch.final_item   = (count_reg == count_t'(1));
    assign out_ch.overflowed   = drop_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input and output open together");

    a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> head_valid)
        else $error("result offered from an empty head cell");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("element count beyond capacity");

    a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_ch.final_item) |=> (count_reg == '0 && !drop_reg
            && in_ch.ready && !head_valid))
        else $error("block not cleared after batch");

    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.batch_end) |=> (out_ch.valid && count_reg != '0))
        else $error("closing element did not start draining");
`endif

endmodule
